// File: hw/rtl/ffba_pkg.sv
// shared types and constants for the first-fit block allocator
// no dependencies; imported by ffba_engine, first_fit_block_allocator, ffba_checker and testbench
`default_nettype none

package ffba_pkg;

  localparam int HEAP_BLOCKS_DEF = 4096;
  localparam int HDR_BLOCKS_DEF  = 1;

  // result codes
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_NO_SPACE       = 3'd1;
  localparam logic [2:0] ST_NONE_ALLOCATED = 3'd2;
  localparam logic [2:0] ST_BAD_RANGE      = 3'd3;
  localparam logic [2:0] ST_NOT_START      = 3'd4;

  // request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic        head;
    logic        used;
    logic [15:0] size;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ARD,
    S_ACHK,
    S_FRD,
    S_FCHK,
    S_NCHK,
    S_PRD,
    S_PCHK,
    S_WR2,
    S_RES
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/ffba_engine.sv
// header table memory and the sequencer that walks, splits and merges segments
// depends on ffba_pkg
`default_nettype none

module ffba_engine
  import ffba_pkg::*;
#(
  parameter int HEAP_BLOCKS = HEAP_BLOCKS_DEF,
  parameter int HDR_BLOCKS  = HDR_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic        in_null,
  input  wire logic [15:0] in_req,
  input  wire logic [15:0] in_addr,
  output logic             res_valid,
  input  wire logic        res_ready,
  output result_t          res
);

  localparam int AW   = $clog2(HEAP_BLOCKS);
  localparam int PW   = AW + 1;
  localparam int SUMW = 18;
  localparam logic [SUMW-1:0] HEAP_S = SUMW'(HEAP_BLOCKS);
  localparam logic [SUMW-1:0] HDR_S  = SUMW'(HDR_BLOCKS);
  localparam logic [15:0]     HDR_16 = 16'(HDR_BLOCKS);

  entry_t mem [HEAP_BLOCKS];
  entry_t rd_data_r;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] s_r, s_nxt;
  logic [AW-1:0] h_r, h_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic          prev_used_r, prev_used_nxt;
  logic [15:0]   prev_size_r, prev_size_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic [15:0]   req_r, req_nxt;
  logic [15:0]   hsize_r, hsize_nxt;
  logic [AW-1:0] wr2_addr_r, wr2_addr_nxt;
  entry_t        wr2_data_r, wr2_data_nxt;
  result_t       res_r, res_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data;

  entry_t          e;
  logic            clr_last, s_end, a_fit, a_split, f_ok, n_in, n_merge, p_more, p_hit;
  logic [15:0]     rem;
  logic [SUMW-1:0] a_next, s_step, n_addr, hs_merged, prev_merged, a_pay, h_calc;
  logic [SUMW-1:0] addr_s;
  logic [2:0]      free_status;
  logic            free_err;
  entry_t          init_entry;

  assign e          = rd_data_r;
  assign clr_last   = (clr_r == AW'(HEAP_BLOCKS - 1));
  assign init_entry = '{head: 1'b1, used: 1'b0, size: 16'(HEAP_BLOCKS - HDR_BLOCKS)};

  assign s_end   = (SUMW'(s_r) >= HEAP_S);
  assign a_fit   = e.head && !e.used && (e.size >= req_r);
  assign rem     = e.size - req_r;
  assign a_split = (rem >= HDR_16);
  assign a_next  = SUMW'(s_r) + HDR_S + SUMW'(req_r);
  assign a_pay   = SUMW'(s_r) + HDR_S;
  assign s_step  = SUMW'(s_r) + HDR_S + SUMW'(e.size);

  assign addr_s = SUMW'(in_addr);
  assign h_calc = addr_s - HDR_S;
  always_comb begin
    free_err    = 1'b1;
    free_status = ST_OK;
    priority if (cnt_r == '0) begin
      free_status = ST_NONE_ALLOCATED;
    end else if (in_null || addr_s > HEAP_S) begin
      free_status = ST_BAD_RANGE;
    end else if (addr_s < HDR_S || h_calc >= HEAP_S) begin
      free_status = ST_NOT_START;
    end else begin
      free_err = 1'b0;
    end
  end

  assign f_ok        = e.head && e.used;
  assign n_addr      = SUMW'(h_r) + HDR_S + SUMW'(e.size);
  assign n_in        = (n_addr < HEAP_S);
  assign n_merge     = e.head && !e.used;
  assign hs_merged   = SUMW'(hsize_r) + HDR_S + SUMW'(e.size);
  assign p_more      = (s_r < PW'(h_r));
  assign p_hit       = have_prev_r && (s_r == PW'(h_r)) && !prev_used_r;
  assign prev_merged = SUMW'(prev_size_r) + HDR_S + SUMW'(hsize_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_FREE) state_nxt = free_err ? S_RES : S_FRD;
          else                       state_nxt = S_ARD;
        end
      end
      S_ARD:  state_nxt = s_end ? S_RES : S_ACHK;
      S_ACHK: state_nxt = a_fit ? (a_split ? S_WR2 : S_RES) : S_ARD;
      S_FRD:  state_nxt = S_FCHK;
      S_FCHK: state_nxt = !f_ok ? S_RES : (n_in ? S_NCHK : S_PRD);
      S_NCHK: state_nxt = S_PRD;
      S_PRD:  state_nxt = p_more ? S_PCHK : (p_hit ? S_WR2 : S_RES);
      S_PCHK: state_nxt = S_PRD;
      S_WR2:  state_nxt = S_RES;
      S_RES:  if (res_ready) state_nxt = S_IDLE;
    endcase
  end

  // memory control and datapath
  always_comb begin
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    s_nxt         = s_r;
    h_nxt         = h_r;
    n_nxt         = n_r;
    prev_nxt      = prev_r;
    prev_used_nxt = prev_used_r;
    prev_size_nxt = prev_size_r;
    have_prev_nxt = have_prev_r;
    req_nxt       = req_r;
    hsize_nxt     = hsize_r;
    wr2_addr_nxt  = wr2_addr_r;
    wr2_data_nxt  = wr2_data_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = (clr_r == '0) ? init_entry : '0;
        clr_nxt = clr_last ? '0 : clr_r + AW'(1);
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req;
          s_nxt   = '0;
          h_nxt   = h_calc[AW-1:0];
          res_nxt = '{status: free_status, payload: 16'd0};
        end
      end
      S_ARD: begin
        if (s_end) begin
          res_nxt = '{status: ST_NO_SPACE, payload: 16'd0};
        end else begin
          rd_en   = 1'b1;
          rd_addr = s_r[AW-1:0];
        end
      end
      S_ACHK: begin
        if (a_fit) begin
          cnt_nxt = cnt_r + PW'(1);
          res_nxt = '{status: ST_OK, payload: a_pay[15:0]};
          if (a_split) begin
            wr_en        = (a_next < HEAP_S);
            wr_addr      = a_next[AW-1:0];
            wr_data      = '{head: 1'b1, used: 1'b0, size: rem - HDR_16};
            wr2_addr_nxt = s_r[AW-1:0];
            wr2_data_nxt = '{head: 1'b1, used: 1'b1, size: req_r};
          end else begin
            wr_en   = 1'b1;
            wr_addr = s_r[AW-1:0];
            wr_data = '{head: 1'b1, used: 1'b1, size: e.size};
          end
        end else begin
          s_nxt = s_step[PW-1:0];
        end
      end
      S_FRD: begin
        rd_en   = 1'b1;
        rd_addr = h_r;
      end
      S_FCHK: begin
        if (!f_ok) begin
          res_nxt = '{status: ST_NOT_START, payload: 16'd0};
        end else begin
          cnt_nxt       = cnt_r - PW'(1);
          hsize_nxt     = e.size;
          res_nxt       = '{status: ST_OK, payload: 16'd0};
          s_nxt         = '0;
          have_prev_nxt = 1'b0;
          n_nxt         = n_addr[AW-1:0];
          rd_en         = n_in;
          rd_addr       = n_addr[AW-1:0];
        end
      end
      S_NCHK: begin
        // absorb the following free segment
        if (n_merge) begin
          hsize_nxt = hs_merged[15:0];
          wr_en     = 1'b1;
          wr_addr   = n_r;
          wr_data   = '0;
        end
      end
      S_PRD: begin
        if (p_more) begin
          rd_en   = 1'b1;
          rd_addr = s_r[AW-1:0];
        end else if (p_hit) begin
          wr_en        = 1'b1;
          wr_addr      = prev_r;
          wr_data      = '{head: 1'b1, used: 1'b0, size: prev_merged[15:0]};
          wr2_addr_nxt = h_r;
          wr2_data_nxt = '0;
        end else begin
          wr_en   = 1'b1;
          wr_addr = h_r;
          wr_data = '{head: 1'b1, used: 1'b0, size: hsize_r};
        end
      end
      S_PCHK: begin
        prev_nxt      = s_r[AW-1:0];
        prev_used_nxt = e.used;
        prev_size_nxt = e.size;
        have_prev_nxt = 1'b1;
        s_nxt         = s_step[PW-1:0];
      end
      S_WR2: begin
        wr_en   = 1'b1;
        wr_addr = wr2_addr_r;
        wr_data = wr2_data_r;
      end
      S_RES: begin
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RES);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    h_r         <= h_nxt;
    n_r         <= n_nxt;
    prev_r      <= prev_nxt;
    prev_used_r <= prev_used_nxt;
    prev_size_r <= prev_size_nxt;
    have_prev_r <= have_prev_nxt;
    req_r       <= req_nxt;
    hsize_r     <= hsize_nxt;
    wr2_addr_r  <= wr2_addr_nxt;
    wr2_data_r  <= wr2_data_nxt;
    res_r       <= res_nxt;
  end

  // sequencing keeps a read and a write of the same entry apart
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en && (wr_addr == rd_addr)))
    else $error("read and write of the same entry in one cycle");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FCHK && f_ok) |-> (cnt_r != '0))
    else $error("allocation count underflow");

  a_free_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && res_r.status != ST_OK) |-> (res_r.payload == 16'd0))
    else $error("failed request carries a payload");

  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && clr_last) |=> (state_r == S_IDLE && clr_r == '0))
    else $error("clearing pass did not end cleanly");

endmodule

`default_nettype wire

// File: hw/rtl/first_fit_block_allocator.sv
// First-fit block allocator with coalescing. After reset the header table is
// swept once, one entry per cycle, so the block accepts no transfer until the
// sweep is done. An allocate walks segment headers in address order, reading
// each segment visited from memory and then checking it; a free checks the
// freed segment and the one after it, then walks the segments lying before the
// freed one to find its predecessor, through the same header memory. One
// request is worked on at a time; a finished result sits in an output register
// while the next request is taken.
// depends on ffba_pkg and ffba_engine
`default_nettype none

module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int HEAP_BLOCKS = HEAP_BLOCKS_DEF,
  parameter int HDR_BLOCKS  = HDR_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // request_blocks[15:0], block_address[31:16]
  input  wire logic [1:0]  in_tuser,  // action[0], pointer_is_null[1]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata  // status[2:0], payload_block[18:3], zero[23:19]
);

  logic      res_valid, res_ready;
  result_t   res;
  logic      out_tvalid_r;
  logic [23:0] out_tdata_r;

  ffba_engine #(
    .HEAP_BLOCKS(HEAP_BLOCKS),
    .HDR_BLOCKS (HDR_BLOCKS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser[0]),
    .in_null   (in_tuser[1]),
    .in_req    (in_tdata[15:0]),
    .in_addr   (in_tdata[31:16]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_tdata_r <= {5'd0, res.payload, res.status};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// File: verif/ffba_checker.sv
// result checker for the first-fit block allocator: watches both streams,
// predicts each response from its own copy of the segment table, compares
// depends on ffba_pkg
`timescale 1ns / 100ps

module ffba_checker
  import ffba_pkg::*;
#(
  parameter int HEAP_BLOCKS = HEAP_BLOCKS_DEF,
  parameter int HDR_BLOCKS  = HDR_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,
  output int               fail_count,
  output int               pending,
  output int               ok_allocs,
  output int               ok_frees
);

  bit          seg_head [HEAP_BLOCKS];
  bit          seg_used [HEAP_BLOCKS];
  int unsigned seg_size [HEAP_BLOCKS];
  int unsigned live_segs;
  result_t     expected_results [$];

  function automatic result_t heap_alloc(int unsigned req);
    result_t     r;
    int unsigned s;
    int unsigned rest;
    int unsigned n;
    r.status  = ST_NO_SPACE;
    r.payload = '0;
    s = 0;
    while (s < HEAP_BLOCKS) begin
      if (seg_head[s] && !seg_used[s] && seg_size[s] >= req) break;
      s += HDR_BLOCKS + seg_size[s];
    end
    if (s >= HEAP_BLOCKS) return r;
    rest = seg_size[s] - req;
    if (rest >= HDR_BLOCKS) begin
      n = s + HDR_BLOCKS + req;
      if (n < HEAP_BLOCKS) begin
        seg_head[n] = 1;
        seg_used[n] = 0;
        seg_size[n] = rest - HDR_BLOCKS;
      end
      seg_size[s] = req;
    end
    seg_used[s] = 1;
    live_segs++;
    r.status  = ST_OK;
    r.payload = 16'((s + HDR_BLOCKS) & 32'hFFFF);
    return r;
  endfunction

  function automatic logic [2:0] heap_free(int unsigned addr, bit is_null);
    int unsigned h;
    int unsigned n;
    int unsigned p;
    int unsigned prv;
    bit          has_prv;
    if (live_segs == 0) return ST_NONE_ALLOCATED;
    if (is_null || addr > HEAP_BLOCKS) return ST_BAD_RANGE;
    if (addr < HDR_BLOCKS) return ST_NOT_START;
    h = addr - HDR_BLOCKS;
    if (h >= HEAP_BLOCKS) return ST_NOT_START;
    if (!seg_head[h] || !seg_used[h]) return ST_NOT_START;
    seg_used[h] = 0;
    live_segs--;
    n = h + HDR_BLOCKS + seg_size[h];
    if (n < HEAP_BLOCKS && seg_head[n] && !seg_used[n]) begin
      seg_size[h] += HDR_BLOCKS + seg_size[n];
      seg_head[n] = 0;
      seg_used[n] = 0;
      seg_size[n] = 0;
    end
    p = 0;
    prv = 0;
    has_prv = 0;
    while (p < h) begin
      prv = p;
      has_prv = 1;
      p += HDR_BLOCKS + seg_size[p];
    end
    if (has_prv && p == h && !seg_used[prv]) begin
      seg_size[prv] += HDR_BLOCKS + seg_size[h];
      seg_head[h] = 0;
      seg_used[h] = 0;
      seg_size[h] = 0;
    end
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      for (int i = 0; i < HEAP_BLOCKS; i++) begin
        seg_head[i] = 0;
        seg_used[i] = 0;
        seg_size[i] = 0;
      end
      seg_head[0] = 1;
      seg_size[0] = HEAP_BLOCKS - HDR_BLOCKS;
      live_segs   = 0;
      fail_count  = 0;
      ok_allocs   = 0;
      ok_frees    = 0;
      expected_results.delete();
      pending     = 0;
    end else begin
      // result side first: a result cannot belong to a request taken this edge
      if (out_tvalid && out_tready) begin
        got.status  = out_tdata[2:0];
        got.payload = out_tdata[18:3];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result status=%0d payload=%0d", got.status, got.payload);
        end else begin
          want = expected_results.pop_front();
          if (got !== want || out_tdata[23:19] !== '0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected status=%0d payload=%0d, %s=%0d payload=%0d pad=%0h",
                       want.status, want.payload, "got status", got.status, got.payload,
                       out_tdata[23:19]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == ACT_ALLOC) begin
          want = heap_alloc(in_tdata[15:0]);
          if (want.status == ST_OK) ok_allocs++;
        end else begin
          want.status  = heap_free(in_tdata[31:16], in_tuser[1]);
          want.payload = '0;
          if (want.status == ST_OK) ok_frees++;
        end
        expected_results.push_back(want);
      end
      pending = expected_results.size();
    end
  end

endmodule

// File: verif/testbench.sv
// top of the allocator testbench: clock, reset, request stimulus and verdict
// depends on ffba_pkg, first_fit_block_allocator and ffba_checker
`timescale 1ns / 100ps

module testbench;
  import ffba_pkg::*;

  localparam int HEAP = HEAP_BLOCKS_DEF;
  localparam int HDR  = HDR_BLOCKS_DEF;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  int          fail_count, pending, ok_allocs, ok_frees;
  int          sent = 0;
  int          stall_mode = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  first_fit_block_allocator #(.HEAP_BLOCKS(HEAP), .HDR_BLOCKS(HDR)) uut (.*);

  ffba_checker #(.HEAP_BLOCKS(HEAP), .HDR_BLOCKS(HDR)) chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .pending, .ok_allocs, .ok_frees
  );

  // receiver stall pattern: phases of always ready, light and heavy stalling
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // one request; optional idle gap before it, waits for the transfer
  task automatic send_req(logic act, logic [15:0] req, logic [15:0] addr, logic is_null,
                          int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {addr, req};
    in_tuser  <= {is_null, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic alloc_req(logic [15:0] req, int gap);
    logic [15:0] bogus;
    bogus = 16'($urandom());
    send_req(ACT_ALLOC, req, bogus, 1'($urandom_range(0, 1)), gap);
  endtask

  task automatic free_req(logic [15:0] addr, logic is_null, int gap);
    send_req(ACT_FREE, 16'($urandom()), addr, is_null, gap);
  endtask

  initial begin
    int burst;
    int gap;
    int pick;
    int unsigned a;
    logic [15:0] sz;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-heap free checks, extremes, zero size, heap end
    free_req(16'd5, 1'b0, 0);
    alloc_req(16'd0, 0);
    free_req(16'd0, 1'b1, 0);
    free_req(16'hFFFF, 1'b0, 0);
    free_req(16'(HEAP + 1), 1'b0, 0);
    free_req(16'd0, 1'b0, 0);
    free_req(16'(HEAP), 1'b0, 0);
    free_req(16'd3, 1'b0, 0);
    alloc_req(16'hFFFF, 0);
    alloc_req(16'(HEAP - HDR - 2), 0);
    alloc_req(16'd1, 0);
    alloc_req(16'd1, 0);
    free_req(16'(HDR), 1'b0, 0);
    free_req(16'(HDR), 1'b0, 0);
    alloc_req(16'd0, 0);
    free_req(16'(2 * HDR), 1'b0, 0);
    free_req(16'(HEAP), 1'b0, 0);
    free_req(16'(HEAP - 1), 1'b0, 0);
    free_req(16'(HEAP - 1 - HDR), 1'b0, 0);
    alloc_req(16'(HEAP - HDR), 0);
    free_req(16'(HDR), 1'b0, 0);
    alloc_req(16'(HEAP - HDR), 0);
    free_req(16'(HDR), 1'b0, 0);

    // random bursts; frees mostly target payload starts of live segments
    while (sent < 900) begin
      burst = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      for (int i = 0; i < burst; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          case ($urandom_range(0, 9))
            0: sz = 16'($urandom());
            1: sz = 16'(HEAP - HDR - $urandom_range(0, 3));
            2: sz = 16'd0;
            3, 4: sz = 16'($urandom_range(0, 400));
            default: sz = 16'($urandom_range(0, 60));
          endcase
          alloc_req(sz, (i == 0) ? gap : 0);
        end else if (pick < 90 && chk.ok_allocs > 0) begin
          // a start address drawn from the tracked live set
          a = chk_live_start();
          free_req(16'(a), 1'b0, (i == 0) ? gap : 0);
        end else begin
          free_req(16'($urandom()), $urandom_range(0, 7) == 0, (i == 0) ? gap : 0);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (4 * HEAP) @(posedge clk);
    $display("%0d requests sent: %0d allocations and %0d frees succeeded", sent, ok_allocs,
             ok_frees);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // live payload starts are read from the checker's mirror of the heap
  function automatic int unsigned chk_live_start();
    int unsigned starts [$];
    for (int s = 0; s < HEAP; s++)
      if (chk.seg_head[s] && chk.seg_used[s]) starts.push_back(s + HDR);
    if (starts.size() == 0) return $urandom_range(0, HEAP);
    return starts[$urandom_range(0, starts.size() - 1)];
  endfunction

  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
